// File: hdl/udiv64_pkg.sv
`default_nettype none

package udiv64_pkg;

  // Control flags that travel with each word down the divider stages
  typedef struct packed {
    logic valid;
    logic div_zero;
  } udiv64_ctl_t;

endpackage

`default_nettype wire

// File: hdl/udiv64_if.sv
`default_nettype none

// Input channel: one dividend/divisor pair per word
interface udiv64_in_if #(
  parameter int DATA_WIDTH = 64
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] dividend;
  logic [DATA_WIDTH-1:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

// Result channel: quotient and divide-by-zero flag per word
interface udiv64_out_if #(
  parameter int DATA_WIDTH = 64
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] quotient;
  logic                  divide_by_zero;

  modport source (output valid, output quotient, output divide_by_zero, input ready);
  modport sink   (input valid, input quotient, input divide_by_zero, output ready);
endinterface

`default_nettype wire

// File: hdl/unsigned_divider_64.sv
`default_nettype none

// Unsigned restoring divider, DATA_WIDTH stages deep. Each stage resolves one
// quotient bit, most significant first, with one (DATA_WIDTH+1)-bit subtract
// and a select. A new word may enter every cycle that the first stage can
// load. Each stage holds its word until the next stage can take it, so a
// stalled output backs the pipeline up one stage at a time while bubbles
// ahead of the stall keep filling. A zero divisor gives an all-ones quotient
// with divide_by_zero set; the remainder is not returned.
module unsigned_divider_64 #(
  parameter int DATA_WIDTH = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  udiv64_in_if.sink         in_ch,
  udiv64_out_if.source      out_ch
);

  // Stage registers: partial remainder, shifting dividend/quotient, divisor
  logic [DATA_WIDTH-1:0]   rem_r  [DATA_WIDTH];
  logic [DATA_WIDTH-1:0]   nq_r   [DATA_WIDTH];
  logic [DATA_WIDTH-1:0]   den_r  [DATA_WIDTH];
  udiv64_pkg::udiv64_ctl_t ctl_r  [DATA_WIDTH];

  // Stage inputs and next values
  logic [DATA_WIDTH-1:0]   src_rem [DATA_WIDTH];
  logic [DATA_WIDTH-1:0]   src_nq  [DATA_WIDTH];
  logic [DATA_WIDTH-1:0]   src_den [DATA_WIDTH];
  udiv64_pkg::udiv64_ctl_t src_ctl [DATA_WIDTH];
  logic [DATA_WIDTH-1:0]   rem_nxt [DATA_WIDTH];
  logic [DATA_WIDTH-1:0]   nq_nxt  [DATA_WIDTH];

  // A stage can load when it is empty or its word moves on this cycle
  logic [DATA_WIDTH:0]     stage_rdy;

  assign stage_rdy[DATA_WIDTH] = out_ch.ready;
  assign in_ch.ready           = stage_rdy[0];

  for (genvar s = 0; s < DATA_WIDTH; s++) begin : g_stage
    logic [DATA_WIDTH:0] trial;
    logic [DATA_WIDTH:0] diff;
    logic                take;

    // Feed the first stage from the channel, the rest from the stage before
    if (s == 0) begin : g_first
      assign src_rem[s]          = '0;
      assign src_nq[s]           = in_ch.dividend;
      assign src_den[s]          = in_ch.divisor;
      assign src_ctl[s].valid    = in_ch.valid;
      assign src_ctl[s].div_zero = (in_ch.divisor == '0);
    end else begin : g_next
      assign src_rem[s] = rem_r[s-1];
      assign src_nq[s]  = nq_r[s-1];
      assign src_den[s] = den_r[s-1];
      assign src_ctl[s] = ctl_r[s-1];
    end

    // Shift in the next dividend bit, subtract the divisor if it fits
    assign trial      = {src_rem[s], src_nq[s][DATA_WIDTH-1]};
    assign diff       = trial - {1'b0, src_den[s]};
    assign take       = ~diff[DATA_WIDTH];
    assign rem_nxt[s] = take ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
    assign nq_nxt[s]  = {src_nq[s][DATA_WIDTH-2:0], take};

    assign stage_rdy[s] = ~ctl_r[s].valid | stage_rdy[s+1];

    // Advance control when the stage can load
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s] <= '0;
      end else if (stage_rdy[s]) begin
        ctl_r[s] <= src_ctl[s];
      end
    end

    // Load payload only with a valid word
    always_ff @(posedge clk) begin
      if (stage_rdy[s] && src_ctl[s].valid) begin
        rem_r[s] <= rem_nxt[s];
        nq_r[s]  <= nq_nxt[s];
        den_r[s] <= src_den[s];
      end
    end
  end

  // Drive the result channel from the last stage
  assign out_ch.valid          = ctl_r[DATA_WIDTH-1].valid;
  assign out_ch.quotient       = nq_r[DATA_WIDTH-1];
  assign out_ch.divide_by_zero = ctl_r[DATA_WIDTH-1].div_zero;

endmodule

`default_nettype wire

// File: hdl/udiv64_checker.sv
`default_nettype none

module udiv64_checker #(
  parameter int DATA_WIDTH = 64
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [DATA_WIDTH-1:0] out_quotient,
  input wire logic                  out_divide_by_zero
);

  localparam int CNT_W = $clog2(DATA_WIDTH + 2);

  logic             in_fire;
  logic             out_fire;
  logic [CNT_W-1:0] pend_r;
  logic [CNT_W-1:0] pend_nxt;

  assign in_fire  = in_valid & in_ready;
  assign out_fire = out_valid & out_ready;

  // Track words accepted but not yet delivered
  always_comb begin
    pend_nxt = pend_r;
    if (in_fire && !out_fire) begin
      pend_nxt = pend_r + CNT_W'(1);
    end else if (!in_fire && out_fire) begin
      pend_nxt = pend_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_quotient)
      && $stable(out_divide_by_zero))
    else $error("result changed while stalled");

  // Zero divisor gives an all-ones quotient
  a_dbz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> out_quotient == '1)
    else $error("divide by zero without all-ones quotient");

  // No result without a word in flight
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result with no word outstanding");

  // Pipeline empty right after reset
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind unsigned_divider_64 udiv64_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_udiv64_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_quotient       (out_ch.quotient),
  .out_divide_by_zero (out_ch.divide_by_zero)
);

`default_nettype wire

// File: verif/tb_unsigned_divider_64.sv
`default_nettype none

module tb_unsigned_divider_64;

  localparam int W          = 64;
  localparam int IDLE_LIMIT = 2000;
  localparam int N_DIRECTED = 22;
  localparam int N_RANDOM   = 830;

  typedef struct packed {
    logic [W-1:0] quotient;
    logic         div_zero;
  } quot_word_t;

  // One directed division; typed rows carry the quotient to expect
  typedef struct packed {
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
    bit           typed;
    logic [W-1:0] quotient;
    logic         div_zero;
  } directed_row_t;

  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    '{64'h0, 64'h0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1},
    '{64'h1, 64'h0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1},
    '{64'h0, 64'h1, 1'b1, 64'h0, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h1, 1'b0},
    '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0, 1'b0},
    '{64'h1, 64'h1, 1'b1, 64'h1, 1'b0},
    '{64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b1, 64'h1, 1'b0},
    '{64'h8000_0000_0000_0000, 64'h1, 1'b1, 64'h8000_0000_0000_0000, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'h2, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 1'b1, 64'h1, 1'b0},
    '{64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 1'b1, 64'h0, 1'b0},
    '{64'd100, 64'd7, 1'b0, 64'h0, 1'b0},
    '{64'hDEAD_BEEF_CAFE_F00D, 64'h1234_5678, 1'b0, 64'h0, 1'b0},
    '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 64'h0, 1'b0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1, 64'h2, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF, 1'b1, 64'h1_0000_0001, 1'b0},
    '{64'd123456789012345678, 64'd1000, 1'b0, 64'h0, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'h3, 1'b1, 64'h5555_5555_5555_5555, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'h1_0000_0000, 1'b1, 64'hFFFF_FFFF, 1'b0}
  };

  logic clk;
  logic rst_n;

  udiv64_in_if  #(.DATA_WIDTH(W)) in_ch ();
  udiv64_out_if #(.DATA_WIDTH(W)) out_ch ();

  unsigned_divider_64 #(.DATA_WIDTH(W)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  quot_word_t quotient_queue [$];
  int         error_count;
  int         checked_count;
  int         zero_div_count;
  int         random_count;
  int         idle_cycles;
  bit         ready_bursts;
  int         stall_left;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Restoring long division over W bits, most significant bit first
  function automatic quot_word_t restoring_quotient(input logic [W-1:0] num,
                                                    input logic [W-1:0] den);
    logic [W:0]   partial;
    logic [W-1:0] quo;
    int           b;
    partial = '0;
    quo     = '0;
    for (b = W - 1; b >= 0; b--) begin
      partial = {partial[W-1:0], num[b]};
      if (partial >= {1'b0, den}) begin
        partial = partial - {1'b0, den};
        quo[b]  = 1'b1;
      end
    end
    return '{quo, (den == '0)};
  endfunction

  // Operand with a random bit length, or an edge value: all ones, a single set bit, or a run of low ones
  function automatic logic [W-1:0] rand_operand();
    logic [W-1:0] r;
    int           k;
    r = {$urandom, $urandom};
    k = $urandom_range(0, W - 1);
    case ($urandom_range(0, 3))
      0: return r;
      1: return r >> $urandom_range(1, W - 1);
      2: return r >> $urandom_range(W - 8, W - 1);
      default: begin
        case ($urandom_range(0, 2))
          0: return {W{1'b1}};
          1: return {{(W-1){1'b0}}, 1'b1} << k;
          default: return ({{(W-1){1'b0}}, 1'b1} << k) - 1'b1;
        endcase
      end
    endcase
  endfunction

  // Gap before the next word: mostly none or short, a few long
  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one word, hold it until accepted, then log its expectation
  task automatic send_word(input logic [W-1:0] num, input logic [W-1:0] den,
                           input quot_word_t want, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.dividend <= num;
    in_ch.divisor  <= den;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    quotient_queue.push_back(want);
    if (den == '0) zero_div_count++;
  endtask

  // Drop valid and hold off until every expected quotient is back
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (quotient_queue.size() != 0) @(negedge clk);
  endtask

  // Result side: stretches with ready held high, others with random stalls
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) ready_bursts <= ~ready_bursts;
    if (stall_left != 0) begin
      stall_left      <= stall_left - 1;
      out_ch.ready    <= 1'b0;
    end else if (!ready_bursts && $urandom_range(0, 3) == 0) begin
      stall_left      <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 2);
      out_ch.ready    <= 1'b0;
    end else begin
      out_ch.ready    <= 1'b1;
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin : check_result
    quot_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (quotient_queue.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result word quotient=%h divide_by_zero=%b",
                 $time, out_ch.quotient, out_ch.divide_by_zero);
      end else begin
        want = quotient_queue.pop_front();
        checked_count++;
        if (out_ch.quotient !== want.quotient) begin
          error_count++;
          $display("%0t: quotient expected %h actual %h",
                   $time, want.quotient, out_ch.quotient);
        end
        if (out_ch.divide_by_zero !== want.div_zero) begin
          error_count++;
          $display("%0t: divide_by_zero expected %b actual %b",
                   $time, want.div_zero, out_ch.divide_by_zero);
        end
      end
    end
  end

  // Watchdog: end the run after too many cycles without a handshake
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d words outstanding",
               $time, IDLE_LIMIT, quotient_queue.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stimulus
  initial begin : stimulus
    logic [W-1:0] num;
    logic [W-1:0] den;
    bit           burst;
    int           sel;
    in_ch.valid    = 1'b0;
    in_ch.dividend = '0;
    in_ch.divisor  = '0;
    out_ch.ready   = 1'b0;
    rst_n          = 1'b0;
    error_count    = 0;
    checked_count  = 0;
    zero_div_count = 0;
    random_count   = 0;
    idle_cycles    = 0;
    ready_bursts   = 1'b0;
    stall_left     = 0;
    burst          = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table: extremes, zero divisor, edge patterns
    foreach (DIRECTED[i]) begin
      send_word(DIRECTED[i].dividend, DIRECTED[i].divisor,
                DIRECTED[i].typed ? quot_word_t'({DIRECTED[i].quotient,
                                                  DIRECTED[i].div_zero})
                                  : restoring_quotient(DIRECTED[i].dividend,
                                                       DIRECTED[i].divisor),
                pick_gap(1'b0));
    end
    drain_results();

    // Random divisions with mixed operand shapes
    for (int n = 0; n < N_RANDOM; n++) begin
      if ($urandom_range(0, 99) == 0) burst = ~burst;
      num = rand_operand();
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
        den = '0;
      end else if (sel < 14) begin
        den = num;
      end else if (sel < 24) begin
        den = rand_operand() >> $urandom_range(32, W - 1);
        num = den * $urandom_range(0, 1000) + $urandom_range(0, 3);
      end else begin
        den = rand_operand();
      end
      send_word(num, den, restoring_quotient(num, den), pick_gap(burst));
      random_count++;
      if (n == N_RANDOM / 2) drain_results();
    end

    drain_results();
    repeat (W + 8) @(posedge clk);

    if (quotient_queue.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected quotients never arrived",
               $time, quotient_queue.size());
    end
    $display("Ran %0d directed and %0d random divisions, %0d with a zero divisor;",
             N_DIRECTED, random_count, zero_div_count);
    $display("compared %0d result words under random input gaps and output stalls.",
             checked_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
